>>> rtl/core/rmq_pkg.sv
package rmq_pkg;

    // Fixed-point format and derived widths
    localparam int FRAC_BITS = 16;
    localparam int E_W       = 18;                       // element / component width
    localparam int S_W       = E_W + 2;                  // sum of three elements
    localparam int D_W       = E_W + 1;                  // sum of two elements, magnitude
    localparam int ARG_W     = E_W + 1;                  // positive root argument
    localparam int RAD_W     = ((ARG_W + FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int DEN_W     = ROOT_W + 1;
    localparam int NUM_W     = D_W + FRAC_BITS + 1;
    localparam int Q_W       = E_W;
    localparam int CMP_W     = DEN_W + Q_W;

    // Saturation limits
    localparam logic [Q_W-1:0] QMAG_POS = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] QMAG_NEG = {1'b1, {(Q_W-1){1'b0}}};

    // Component taken from the root
    localparam logic [1:0] SLOT_QW = 2'd0;
    localparam logic [1:0] SLOT_QX = 2'd1;
    localparam logic [1:0] SLOT_QY = 2'd2;
    localparam logic [1:0] SLOT_QZ = 2'd3;

    typedef struct packed {
        logic signed [E_W-1:0] r0c0;
        logic signed [E_W-1:0] r0c1;
        logic signed [E_W-1:0] r0c2;
        logic signed [E_W-1:0] r1c0;
        logic signed [E_W-1:0] r1c1;
        logic signed [E_W-1:0] r1c2;
        logic signed [E_W-1:0] r2c0;
        logic signed [E_W-1:0] r2c1;
        logic signed [E_W-1:0] r2c2;
    } rmq_mat_t;

    // Per-item side data carried alongside the root and the quotients
    typedef struct packed {
        logic                  inv;
        logic [1:0]            slot;
        logic [2:0]            neg;
        logic [2:0][D_W-1:0]   mag;
    } rmq_job_t;

    // Signed, saturated component from a quotient magnitude
    function automatic logic [E_W-1:0] sat_lane(logic neg, logic ovf, logic [Q_W-1:0] quo);
        logic [E_W-1:0] r;
        if (!neg)
            r = (ovf || (quo > QMAG_POS)) ? E_W'(QMAG_POS) : E_W'(quo);
        else
            r = (ovf || (quo > QMAG_NEG)) ? E_W'(QMAG_NEG) : E_W'(Q_W'(0) - quo);
        return r;
    endfunction

endpackage

>>> rtl/core/rmq_if.sv
interface rmq_mat_if;
    logic                            valid;
    logic                            ready;
    logic signed [rmq_pkg::E_W-1:0]  e_r0c0;
    logic signed [rmq_pkg::E_W-1:0]  e_r0c1;
    logic signed [rmq_pkg::E_W-1:0]  e_r0c2;
    logic signed [rmq_pkg::E_W-1:0]  e_r1c0;
    logic signed [rmq_pkg::E_W-1:0]  e_r1c1;
    logic signed [rmq_pkg::E_W-1:0]  e_r1c2;
    logic signed [rmq_pkg::E_W-1:0]  e_r2c0;
    logic signed [rmq_pkg::E_W-1:0]  e_r2c1;
    logic signed [rmq_pkg::E_W-1:0]  e_r2c2;

    modport source (output valid, e_r0c0, e_r0c1, e_r0c2, e_r1c0, e_r1c1, e_r1c2,
                    e_r2c0, e_r2c1, e_r2c2, input ready);
    modport sink   (input valid, e_r0c0, e_r0c1, e_r0c2, e_r1c0, e_r1c1, e_r1c2,
                    e_r2c0, e_r2c1, e_r2c2, output ready);
endinterface

interface rmq_quat_if;
    logic                            valid;
    logic                            ready;
    logic signed [rmq_pkg::E_W-1:0]  quat_w;
    logic signed [rmq_pkg::E_W-1:0]  quat_x;
    logic signed [rmq_pkg::E_W-1:0]  quat_y;
    logic signed [rmq_pkg::E_W-1:0]  quat_z;
    logic                            invalid;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, invalid, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, invalid, output ready);
endinterface

>>> rtl/core/rotation_matrix_to_quaternion_top.sv
// Throughput: one matrix per cycle unless the result stalls; depth is set by the
// square root (one root bit per stage, 18 stages) and the divider (one quotient
// bit per stage, 18 stages).
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears every stage valid bit; data is not reset.
module rotation_matrix_to_quaternion_top (
    input  logic     clk,
    input  logic     rst_n,
    rmq_mat_if.sink  mat,
    rmq_quat_if.source quat
);

    logic                             en;
    rmq_pkg::rmq_mat_t                mat_in;

    logic                             f_vld;
    logic [rmq_pkg::ARG_W-1:0]        f_arg;
    rmq_pkg::rmq_job_t                f_job;

    logic                             s_vld;
    logic [rmq_pkg::ROOT_W-1:0]       s_root;
    rmq_pkg::rmq_job_t                s_job;

    logic                             d_vld;
    logic [rmq_pkg::ROOT_W-1:0]       d_root;
    rmq_pkg::rmq_job_t                d_job;
    logic [2:0]                       d_ovf;
    logic [2:0][rmq_pkg::Q_W-1:0]     d_quo;

    logic                             out_vld_reg;

    // Whole pipe advances whenever the output register can take a result
    assign en        = !out_vld_reg || quat.ready;
    assign mat.ready = en;

    assign mat_in.r0c0 = mat.e_r0c0;
    assign mat_in.r0c1 = mat.e_r0c1;
    assign mat_in.r0c2 = mat.e_r0c2;
    assign mat_in.r1c0 = mat.e_r1c0;
    assign mat_in.r1c1 = mat.e_r1c1;
    assign mat_in.r1c2 = mat.e_r1c2;
    assign mat_in.r2c0 = mat.e_r2c0;
    assign mat_in.r2c1 = mat.e_r2c1;
    assign mat_in.r2c2 = mat.e_r2c2;

    rmq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (mat.valid),
        .mat     (mat_in),
        .out_vld (f_vld),
        .arg     (f_arg),
        .job     (f_job)
    );

    rmq_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (f_vld),
        .arg     (f_arg),
        .job_in  (f_job),
        .out_vld (s_vld),
        .root    (s_root),
        .job_out (s_job)
    );

    rmq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s_vld),
        .root_in  (s_root),
        .job_in   (s_job),
        .out_vld  (d_vld),
        .root_out (d_root),
        .job_out  (d_job),
        .ovf      (d_ovf),
        .quo      (d_quo)
    );

    // Final stage: saturate, place lanes, blank rejected items
    logic [rmq_pkg::ROOT_W:0]  main_sum;
    logic [rmq_pkg::E_W-1:0]   main_val;
    logic [rmq_pkg::E_W-1:0]   lv [3];
    logic [rmq_pkg::E_W-1:0]   w_next, x_next, y_next, z_next;

    logic [rmq_pkg::E_W-1:0]   w_reg, x_reg, y_reg, z_reg;
    logic                      inv_reg;

    always_comb
    begin
        main_sum = rmq_pkg::ROOT_W'(d_root) + (rmq_pkg::ROOT_W + 1)'(1);
        main_val = rmq_pkg::E_W'(main_sum[rmq_pkg::ROOT_W:1]);
        for (int l = 0; l < 3; l++)
            lv[l] = rmq_pkg::sat_lane(d_job.neg[l], d_ovf[l], d_quo[l]);
        unique case (d_job.slot)
            rmq_pkg::SLOT_QW:
            begin
                w_next = main_val; x_next = lv[0]; y_next = lv[1]; z_next = lv[2];
            end
            rmq_pkg::SLOT_QX:
            begin
                w_next = lv[0]; x_next = main_val; y_next = lv[1]; z_next = lv[2];
            end
            rmq_pkg::SLOT_QY:
            begin
                w_next = lv[0]; x_next = lv[1]; y_next = main_val; z_next = lv[2];
            end
            default:
            begin
                w_next = lv[0]; x_next = lv[1]; y_next = lv[2]; z_next = main_val;
            end
        endcase
        if (d_job.inv)
        begin
            w_next = '0;
            x_next = '0;
            y_next = '0;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg   <= w_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            inv_reg <= d_job.inv;
        end
    end

    assign quat.valid   = out_vld_reg;
    assign quat.quat_w  = w_reg;
    assign quat.quat_x  = x_reg;
    assign quat.quat_y  = y_reg;
    assign quat.quat_z  = z_reg;
    assign quat.invalid = inv_reg;

endmodule

>>> rtl/core/rmq_front.sv
module rmq_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  rmq_pkg::rmq_mat_t             mat,
    output logic                          out_vld,
    output logic [rmq_pkg::ARG_W-1:0]     arg,
    output rmq_pkg::rmq_job_t             job
);

    localparam logic signed [rmq_pkg::S_W-1:0] ARG_ONE = rmq_pkg::S_W'(1 << rmq_pkg::FRAC_BITS);

    // Stage 1: trace, diagonal order, root arguments, pair sums
    logic signed [rmq_pkg::S_W-1:0] x00, x11, x22;
    logic signed [rmq_pkg::S_W-1:0] tr_next;
    logic signed [rmq_pkg::S_W-1:0] argw_next, arg0_next, arg1_next, arg2_next;
    logic [1:0]                     idx_next;
    logic signed [rmq_pkg::D_W-1:0] pa_next, pb_next, pc_next, pp_next, pq_next, pr_next;

    logic                           vld1_reg;
    logic                           wb_reg;
    logic [1:0]                     idx_reg;
    logic signed [rmq_pkg::S_W-1:0] argw_reg, arg0_reg, arg1_reg, arg2_reg;
    logic signed [rmq_pkg::D_W-1:0] pa_reg, pb_reg, pc_reg, pp_reg, pq_reg, pr_reg;

    always_comb
    begin
        x00       = rmq_pkg::S_W'(mat.r0c0);
        x11       = rmq_pkg::S_W'(mat.r1c1);
        x22       = rmq_pkg::S_W'(mat.r2c2);
        tr_next   = x00 + x11 + x22;
        argw_next = tr_next + ARG_ONE;
        arg0_next = x00 - (x11 + x22) + ARG_ONE;
        arg1_next = x11 - (x22 + x00) + ARG_ONE;
        arg2_next = x22 - (x00 + x11) + ARG_ONE;
        // ties keep the lower index
        if (mat.r1c1 > mat.r0c0)
            idx_next = (mat.r2c2 > mat.r1c1) ? 2'd2 : 2'd1;
        else
            idx_next = (mat.r2c2 > mat.r0c0) ? 2'd2 : 2'd0;
        pa_next = rmq_pkg::D_W'(mat.r2c1) - rmq_pkg::D_W'(mat.r1c2);
        pb_next = rmq_pkg::D_W'(mat.r0c2) - rmq_pkg::D_W'(mat.r2c0);
        pc_next = rmq_pkg::D_W'(mat.r1c0) - rmq_pkg::D_W'(mat.r0c1);
        pp_next = rmq_pkg::D_W'(mat.r0c1) + rmq_pkg::D_W'(mat.r1c0);
        pq_next = rmq_pkg::D_W'(mat.r2c0) + rmq_pkg::D_W'(mat.r0c2);
        pr_next = rmq_pkg::D_W'(mat.r1c2) + rmq_pkg::D_W'(mat.r2c1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (en)
            vld1_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wb_reg   <= ~tr_next[rmq_pkg::S_W-1];
            idx_reg  <= idx_next;
            argw_reg <= argw_next;
            arg0_reg <= arg0_next;
            arg1_reg <= arg1_next;
            arg2_reg <= arg2_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            pc_reg   <= pc_next;
            pp_reg   <= pp_next;
            pq_reg   <= pq_next;
            pr_reg   <= pr_next;
        end
    end

    // Stage 2: branch selection and lane assignment
    logic signed [rmq_pkg::S_W-1:0] sel_arg;
    logic signed [rmq_pkg::D_W-1:0] lane [3];
    rmq_pkg::rmq_job_t              job_next;
    logic [rmq_pkg::ARG_W-1:0]      arg_next;

    logic                           vld2_reg;
    rmq_pkg::rmq_job_t              job_reg;
    logic [rmq_pkg::ARG_W-1:0]      arg_reg;

    always_comb
    begin
        sel_arg       = argw_reg;
        lane[0]       = pa_reg;
        lane[1]       = pb_reg;
        lane[2]       = pc_reg;
        job_next.slot = rmq_pkg::SLOT_QW;
        if (!wb_reg)
        begin
            unique case (idx_reg)
                2'd0:
                begin
                    sel_arg       = arg0_reg;
                    job_next.slot = rmq_pkg::SLOT_QX;
                    lane[0]       = pa_reg;
                    lane[1]       = pp_reg;
                    lane[2]       = pq_reg;
                end
                2'd1:
                begin
                    sel_arg       = arg1_reg;
                    job_next.slot = rmq_pkg::SLOT_QY;
                    lane[0]       = pb_reg;
                    lane[1]       = pp_reg;
                    lane[2]       = pr_reg;
                end
                default:
                begin
                    sel_arg       = arg2_reg;
                    job_next.slot = rmq_pkg::SLOT_QZ;
                    lane[0]       = pc_reg;
                    lane[1]       = pq_reg;
                    lane[2]       = pr_reg;
                end
            endcase
        end
        job_next.inv = sel_arg[rmq_pkg::S_W-1] || (sel_arg == '0);
        // a dummy argument keeps the divisor non-zero for rejected items
        arg_next = job_next.inv ? rmq_pkg::ARG_W'(1) : sel_arg[rmq_pkg::ARG_W-1:0];
        for (int l = 0; l < 3; l++)
        begin
            job_next.neg[l] = lane[l][rmq_pkg::D_W-1];
            job_next.mag[l] = lane[l][rmq_pkg::D_W-1] ? rmq_pkg::D_W'(-lane[l])
                                                      : rmq_pkg::D_W'(lane[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld2_reg <= 1'b0;
        else if (en)
            vld2_reg <= vld1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            job_reg <= job_next;
            arg_reg <= arg_next;
        end
    end

    assign out_vld = vld2_reg;
    assign arg     = arg_reg;
    assign job     = job_reg;

endmodule

>>> rtl/core/rmq_sqrt.sv
module rmq_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [rmq_pkg::ARG_W-1:0]     arg,
    input  rmq_pkg::rmq_job_t             job_in,
    output logic                          out_vld,
    output logic [rmq_pkg::ROOT_W-1:0]    root,
    output rmq_pkg::rmq_job_t             job_out
);

    localparam int N = rmq_pkg::ROOT_W;

    // One root bit per stage, radicand consumed two bits at a time
    logic [rmq_pkg::RAD_W-1:0]  rad_reg  [N];
    logic [rmq_pkg::REM_W-1:0]  rem_reg  [N];
    logic [rmq_pkg::ROOT_W-1:0] root_reg [N];
    rmq_pkg::rmq_job_t          job_reg  [N];
    logic                       vld_reg  [N];

    logic [rmq_pkg::RAD_W-1:0]  rad_in;

    assign rad_in = rmq_pkg::RAD_W'({arg, {rmq_pkg::FRAC_BITS{1'b0}}});

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [rmq_pkg::RAD_W-1:0]  rad_src;
        logic [rmq_pkg::REM_W-1:0]  rem_src;
        logic [rmq_pkg::ROOT_W-1:0] root_src;
        rmq_pkg::rmq_job_t          job_src;
        logic                       vld_src;
        logic [rmq_pkg::REM_W-1:0]  rem_sh;
        logic [rmq_pkg::REM_W-1:0]  trial;
        logic                       take;

        if (k == 0)
        begin : g_first
            assign rad_src  = rad_in;
            assign rem_src  = '0;
            assign root_src = '0;
            assign job_src  = job_in;
            assign vld_src  = in_vld;
        end
        else
        begin : g_chain
            assign rad_src  = rad_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign job_src  = job_reg[k-1];
            assign vld_src  = vld_reg[k-1];
        end

        // trial subtract of (4*root + 1)
        assign rem_sh = {rem_src[rmq_pkg::REM_W-3:0], rad_src[rmq_pkg::RAD_W-1 -: 2]};
        assign trial  = {root_src, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= {rad_src[rmq_pkg::RAD_W-3:0], 2'b00};
                rem_reg[k]  <= take ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_src[rmq_pkg::ROOT_W-2:0], take};
                job_reg[k]  <= job_src;
            end
        end
    end

    assign out_vld = vld_reg[N-1];
    assign root    = root_reg[N-1];
    assign job_out = job_reg[N-1];

endmodule

>>> rtl/core/rmq_div.sv
module rmq_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic [rmq_pkg::ROOT_W-1:0]        root_in,
    input  rmq_pkg::rmq_job_t                 job_in,
    output logic                              out_vld,
    output logic [rmq_pkg::ROOT_W-1:0]        root_out,
    output rmq_pkg::rmq_job_t                 job_out,
    output logic [2:0]                        ovf,
    output logic [2:0][rmq_pkg::Q_W-1:0]      quo
);

    localparam int N = rmq_pkg::Q_W;

    // Setup: numerator (mag << FRAC_BITS) + s rounds to nearest, divisor 2s
    logic                              vld0_reg;
    logic [rmq_pkg::DEN_W-1:0]         den0_reg;
    logic [2:0][rmq_pkg::NUM_W-1:0]    num0_reg;
    logic [rmq_pkg::ROOT_W-1:0]        root0_reg;
    rmq_pkg::rmq_job_t                 job0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld0_reg <= 1'b0;
        else if (en)
            vld0_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den0_reg  <= {root_in, 1'b0};
            root0_reg <= root_in;
            job0_reg  <= job_in;
            for (int l = 0; l < 3; l++)
                num0_reg[l] <= rmq_pkg::NUM_W'({job_in.mag[l], {rmq_pkg::FRAC_BITS{1'b0}}})
                             + rmq_pkg::NUM_W'(root_in);
        end
    end

    // Overflow: quotient would not fit Q_W bits
    logic                              vld1_reg;
    logic [rmq_pkg::DEN_W-1:0]         den1_reg;
    logic [2:0][rmq_pkg::NUM_W-1:0]    num1_reg;
    logic [2:0]                        ovf1_reg;
    logic [rmq_pkg::ROOT_W-1:0]        root1_reg;
    rmq_pkg::rmq_job_t                 job1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (en)
            vld1_reg <= vld0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den1_reg  <= den0_reg;
            num1_reg  <= num0_reg;
            root1_reg <= root0_reg;
            job1_reg  <= job0_reg;
            for (int l = 0; l < 3; l++)
                ovf1_reg[l] <= (rmq_pkg::CMP_W'(num0_reg[l]) >=
                                {den0_reg, {rmq_pkg::Q_W{1'b0}}});
        end
    end

    // Restoring division, one quotient bit per stage, three lanes
    logic [2:0][rmq_pkg::NUM_W-1:0]    rem_reg  [N];
    logic [2:0][rmq_pkg::Q_W-1:0]      q_reg    [N];
    logic [rmq_pkg::DEN_W-1:0]         den_reg  [N];
    logic [2:0]                        ovf_reg  [N];
    logic [rmq_pkg::ROOT_W-1:0]        root_reg [N];
    rmq_pkg::rmq_job_t                 job_reg  [N];
    logic                              vld_reg  [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [2:0][rmq_pkg::NUM_W-1:0]  rem_src;
        logic [2:0][rmq_pkg::Q_W-1:0]    q_src;
        logic [rmq_pkg::DEN_W-1:0]       den_src;
        logic [2:0]                      ovf_src;
        logic [rmq_pkg::ROOT_W-1:0]      root_src;
        rmq_pkg::rmq_job_t               job_src;
        logic                            vld_src;
        logic [rmq_pkg::CMP_W-1:0]       trial;
        logic [2:0][rmq_pkg::NUM_W-1:0]  rem_next;
        logic [2:0][rmq_pkg::Q_W-1:0]    q_next;

        if (k == 0)
        begin : g_first
            assign rem_src  = num1_reg;
            assign q_src    = '0;
            assign den_src  = den1_reg;
            assign ovf_src  = ovf1_reg;
            assign root_src = root1_reg;
            assign job_src  = job1_reg;
            assign vld_src  = vld1_reg;
        end
        else
        begin : g_chain
            assign rem_src  = rem_reg[k-1];
            assign q_src    = q_reg[k-1];
            assign den_src  = den_reg[k-1];
            assign ovf_src  = ovf_reg[k-1];
            assign root_src = root_reg[k-1];
            assign job_src  = job_reg[k-1];
            assign vld_src  = vld_reg[k-1];
        end

        assign trial = rmq_pkg::CMP_W'(den_src) << (N - 1 - k);

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (rmq_pkg::CMP_W'(rem_src[l]) >= trial)
                begin
                    rem_next[l] = rem_src[l] - trial[rmq_pkg::NUM_W-1:0];
                    q_next[l]   = {q_src[l][rmq_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = rem_src[l];
                    q_next[l]   = {q_src[l][rmq_pkg::Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                den_reg[k]  <= den_src;
                ovf_reg[k]  <= ovf_src;
                root_reg[k] <= root_src;
                job_reg[k]  <= job_src;
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign root_out = root_reg[N-1];
    assign job_out  = job_reg[N-1];
    assign ovf      = ovf_reg[N-1];
    assign quo      = q_reg[N-1];

endmodule

>>> rtl/core/rmq_checker.sv
module rmq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic signed [rmq_pkg::E_W-1:0]  quat_w,
    input logic signed [rmq_pkg::E_W-1:0]  quat_x,
    input logic signed [rmq_pkg::E_W-1:0]  quat_y,
    input logic signed [rmq_pkg::E_W-1:0]  quat_z,
    input logic                            invalid
);

    // Input is held back only by a result that is waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("request ready does not follow the output stall");

    // Rejected matrices give an all-zero quaternion
    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && invalid) |->
        (quat_w == '0 && quat_x == '0 && quat_y == '0 && quat_z == '0))
        else $error("invalid result with non-zero components");

    // A valid result has a positive component, the one taken from the root
    a_main_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !invalid) |->
        (quat_w > 0 || quat_x > 0 || quat_y > 0 || quat_z > 0))
        else $error("valid result without a positive component");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(quat_w) && $stable(quat_x) && $stable(quat_y)
         && $stable(quat_z) && $stable(invalid)))
        else $error("stalled result changed");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mat.valid),
    .in_ready  (mat.ready),
    .out_valid (quat.valid),
    .out_ready (quat.ready),
    .quat_w    (quat.quat_w),
    .quat_x    (quat.quat_x),
    .quat_y    (quat.quat_y),
    .quat_z    (quat.quat_z),
    .invalid   (quat.invalid)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY   = 41;
    localparam int N_RANDOM  = 1150;
    localparam int LONG_HOLD = 200;

    typedef logic signed [rmq_pkg::E_W-1:0] elem_t;

    typedef struct packed {
        elem_t w;
        elem_t x;
        elem_t y;
        elem_t z;
        logic  inv;
    } quat_t;

    // One row of the directed table; has_quat marks a hand-typed expectation
    typedef struct {
        elem_t m [9];
        logic  has_quat;
        quat_t q;
    } stim_row_t;

    logic clk;
    logic rst_n;

    rmq_mat_if  mat ();
    rmq_quat_if quat ();

    rotation_matrix_to_quaternion_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .mat   (mat.sink),
        .quat  (quat.source)
    );

    quat_t pending_quats [$];
    int    mismatches;
    int    n_sent;
    bit    sending_done;
    bit    calm;
    bit    hold_long;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Integer square root by bit pairs
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp18(longint v);
        if (v > 131071)
            return 131071;
        if (v < -131072)
            return -131072;
        return v;
    endfunction

    // d / (2*s), nearest, ties away from zero
    function automatic longint div_by_root(longint d, longint unsigned s);
        longint unsigned den;
        longint unsigned mag;
        longint unsigned qq;
        den = s * 2;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        qq  = ((mag << rmq_pkg::FRAC_BITS) + den / 2) / den;
        return (d < 0) ? -longint'(qq) : longint'(qq);
    endfunction

    function automatic quat_t matrix_to_quat(elem_t e [9]);
        longint m [3][3];
        longint qv [4];
        longint tr;
        longint arg;
        longint one;
        longint unsigned s;
        int     idx;
        quat_t  r;
        one = longint'(1) << rmq_pkg::FRAC_BITS;
        for (int k = 0; k < 9; k++)
            m[k / 3][k % 3] = longint'(e[k]);
        qv = '{0, 0, 0, 0};
        r.inv = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr >= 0)
        begin
            s = int_sqrt(longint'(tr + one) << rmq_pkg::FRAC_BITS);
            qv[0] = (s + 1) >> 1;
            qv[1] = div_by_root(m[2][1] - m[1][2], s);
            qv[2] = div_by_root(m[0][2] - m[2][0], s);
            qv[3] = div_by_root(m[1][0] - m[0][1], s);
        end
        else
        begin
            idx = 0;
            if (m[1][1] > m[0][0])
                idx = 1;
            if (m[2][2] > m[idx][idx])
                idx = 2;
            arg = 2 * m[idx][idx] - tr + one;
            if (arg <= 0)
                r.inv = 1'b1;
            else
            begin
                s = int_sqrt(arg << rmq_pkg::FRAC_BITS);
                qv[idx + 1] = (s + 1) >> 1;
                case (idx)
                    0:
                    begin
                        qv[2] = div_by_root(m[0][1] + m[1][0], s);
                        qv[3] = div_by_root(m[2][0] + m[0][2], s);
                        qv[0] = div_by_root(m[2][1] - m[1][2], s);
                    end
                    1:
                    begin
                        qv[3] = div_by_root(m[1][2] + m[2][1], s);
                        qv[1] = div_by_root(m[0][1] + m[1][0], s);
                        qv[0] = div_by_root(m[0][2] - m[2][0], s);
                    end
                    default:
                    begin
                        qv[1] = div_by_root(m[2][0] + m[0][2], s);
                        qv[2] = div_by_root(m[1][2] + m[2][1], s);
                        qv[0] = div_by_root(m[1][0] - m[0][1], s);
                    end
                endcase
            end
        end
        r.w = elem_t'(clamp18(qv[0]));
        r.x = elem_t'(clamp18(qv[1]));
        r.y = elem_t'(clamp18(qv[2]));
        r.z = elem_t'(clamp18(qv[3]));
        return r;
    endfunction

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 5))
            0:       return elem_t'($urandom);
            1:       return elem_t'(131071 - $urandom_range(0, 3));
            2:       return elem_t'(-131072 + $urandom_range(0, 3));
            default: return elem_t'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // Fully random in three of ten draws; else diagonal in +/-65536, off-diagonal in +/-32768
    function automatic void rand_matrix(output elem_t e [9]);
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
        begin
            if (mode < 3)
                e[k] = rand_elem();
            else if (k % 4 == 0)
                e[k] = elem_t'(int'($urandom_range(0, 131072)) - 65536);
            else
                e[k] = elem_t'(int'($urandom_range(0, 65536)) - 32768);
        end
    endfunction

    // Present one request and wait for its acceptance
    task automatic send_matrix(elem_t e [9]);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            mat.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mat.valid  <= 1'b1;
        mat.e_r0c0 <= e[0];
        mat.e_r0c1 <= e[1];
        mat.e_r0c2 <= e[2];
        mat.e_r1c0 <= e[3];
        mat.e_r1c1 <= e[4];
        mat.e_r1c2 <= e[5];
        mat.e_r2c0 <= e[6];
        mat.e_r2c1 <= e[7];
        mat.e_r2c2 <= e[8];
        do
            @(posedge clk);
        while (!mat.ready);
        pending_quats.push_back(matrix_to_quat(e));
        n_sent++;
        @(negedge clk);
    endtask

    // Sender: directed table, then random requests
    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        elem_t     e [9];
        localparam elem_t ONE = elem_t'(1 << rmq_pkg::FRAC_BITS);
        localparam elem_t MX  = elem_t'(131071);
        localparam elem_t MN  = elem_t'(-131072);

        mat.valid = 1'b0;
        {mat.e_r0c0, mat.e_r0c1, mat.e_r0c2, mat.e_r1c0, mat.e_r1c1,
         mat.e_r1c2, mat.e_r2c0, mat.e_r2c1, mat.e_r2c2} = '0;
        quat.ready = 1'b0;
        rst_n = 1'b0;
        n_sent = 0;
        mismatches = 0;
        sending_done = 0;
        calm = 0;
        hold_long = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // identity: w = 1
        row.m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        row.has_quat = 1;
        row.q = '{ONE, 0, 0, 0, 1'b0};
        rows.push_back(row);
        // zero matrix: trace 0, w = 0.5
        row.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        row.q = '{elem_t'(32768), 0, 0, 0, 1'b0};
        rows.push_back(row);
        row.has_quat = 0;
        // diagonal all minimum: x branch, ties keep index 0
        row.m = '{MN, 0, 0, 0, MN, 0, 0, 0, MN}; rows.push_back(row);
        // 180 degrees about x, y, z
        row.m = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; rows.push_back(row);
        row.m = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}; rows.push_back(row);
        row.m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}; rows.push_back(row);
        // diagonal ties keep the lower index
        row.m = '{-ONE, 5, 7, 3, -ONE, 9, 1, 2, -ONE}; rows.push_back(row);
        row.m = '{-ONE, 5, 7, 3, ONE / 2, 9, 1, 2, ONE / 2}; rows.push_back(row);
        // full-scale elements, some quotients saturate
        row.m = '{MX, MX, MX, MX, MX, MX, MX, MX, MX}; rows.push_back(row);
        row.m = '{MN, MX, MN, MX, MN, MX, MN, MX, MN}; rows.push_back(row);
        row.m = '{0, MN, MX, MX, 0, MN, MN, MX, 0}; rows.push_back(row);
        row.m = '{MN, MX, MX, MX, MX, MN, MX, MN, MN}; rows.push_back(row);
        row.m = '{MN, MN, MN, MN, MN, MN, MN, MN, 0}; rows.push_back(row);
        row.m = '{-1, MX, MN, MN, 0, MX, MX, MN, 0}; rows.push_back(row);
        row.m = '{MN, MX, MN, MN, MX, MX, MX, MN, MN}; rows.push_back(row);
        // 90 degrees about z
        row.m = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE}; rows.push_back(row);

        foreach (rows[i])
        begin
            if (rows[i].has_quat && matrix_to_quat(rows[i].m) != rows[i].q)
            begin
                mismatches++;
                $display("directed row %0d: hand value disagrees with prediction", i);
            end
            send_matrix(rows[i].m);
        end

        // long receiver hold-off while requests keep coming
        hold_long = 1;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - 150)
                calm = 1;
            rand_matrix(e);
            send_matrix(e);
        end
        mat.valid <= 1'b0;
        sending_done = 1;
    end

    // Receiver ready: random stall bursts, one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                quat.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_long = 0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                quat.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            quat.ready <= 1'b1;
            if (!calm)
                repeat ($urandom_range(0, 12)) @(negedge clk);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        quat_t got;
        quat_t want;
        if (rst_n && quat.valid && quat.ready)
        begin
            got = '{quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z, quat.invalid};
            if (pending_quats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quaternion w=%0d x=%0d y=%0d z=%0d inv=%0b",
                             got.w, got.x, got.y, got.z, got.inv);
            end
            else
            begin
                want = pending_quats.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"quat mismatch: exp w=%0d x=%0d y=%0d z=%0d inv=%0b",
                                  " got w=%0d x=%0d y=%0d z=%0d inv=%0b"},
                                 want.w, want.x, want.y, want.z, want.inv,
                                 got.w, got.x, got.y, got.z, got.inv);
                end
            end
        end
    end

    // End of run
    initial
    begin
        wait (sending_done);
        wait (pending_quats.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && pending_quats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rmq_pkg.sv
rtl/core/rmq_if.sv
rtl/core/rmq_front.sv
rtl/core/rmq_sqrt.sv
rtl/core/rmq_div.sv
rtl/core/rotation_matrix_to_quaternion_top.sv
rtl/core/rmq_checker.sv
verif/tb.sv
